[hw/rtl/point_jump_rejection_filter_defines.svh]
// Assertion macros shared by the point jump rejection filter RTL
`ifndef POINT_JUMP_REJECTION_FILTER_DEFINES_SVH
`define POINT_JUMP_REJECTION_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define PJRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PJRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pjrf_pkg.sv]
// Package: widths, reset values and register indexes for the jump rejection filter
package pjrf_pkg;

    localparam int COORD_BITS = 10;
    localparam int REG_BITS   = 10;
    localparam int CNT_BITS   = 10;
    localparam int IDX_BITS   = 1;

    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int THR_BITS   = 2 * REG_BITS;
    localparam int CMP_BITS   = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [REG_BITS-1:0]   t_reg;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [IDX_BITS-1:0]   t_idx;

    localparam t_coord RST_X = COORD_BITS'(320);
    localparam t_coord RST_Y = COORD_BITS'(200);

    localparam t_reg RST_THRESHOLD = REG_BITS'(50);
    localparam t_reg RST_CONFIRM   = REG_BITS'(10);

    localparam t_cnt CNT_MAX = {CNT_BITS{1'b1}};

    localparam t_idx REG_JUMP_THRESHOLD = IDX_BITS'(0);
    localparam t_idx REG_CONFIRM_LENGTH = IDX_BITS'(1);

endpackage

[hw/rtl/point_jump_rejection_filter.sv]
// Path: an accepted input word waits in the input register, then moves to the result register.
// Throughput: one word per cycle while results are taken; the distance compare and state update are combinational.
// The input register takes one word while a result waits; a blocked result then holds the input.
// Reset (i_rst_n low, synchronous): both registers empty, record and previous point
// return to (320,200), jump count to zero, threshold to 50 and confirm length to 10.
module point_jump_rejection_filter
    import pjrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [IDX_BITS-1:0]   i_cfg_index,
    input  logic [REG_BITS-1:0]   i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_filtered_x,
    output logic [COORD_BITS-1:0] o_filtered_y,
    output logic                  o_held
);

`include "point_jump_rejection_filter_defines.svh"

    t_reg   r_threshold, r_confirm;
    t_coord r_prev_x, r_prev_y, r_rec_x, r_rec_y;
    t_coord n_prev_x, n_prev_y, n_rec_x, n_rec_y;
    t_cnt   r_jump_count, n_jump_count;

    logic   r_in_valid;
    t_coord r_in_x, r_in_y;

    logic   r_out_valid;
    t_coord r_out_x, r_out_y;
    logic   r_out_held;
    t_coord n_out_x, n_out_y;
    logic   n_out_held;

    logic   advance;

    logic [COORD_BITS-1:0]   dx, dy;
    logic [2*COORD_BITS-1:0] dx2, dy2;
    logic [CMP_BITS-1:0]     dist2, thr2;
    logic                    is_jump;
    t_cnt                    cnt_inc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_confirm   <= RST_CONFIRM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_JUMP_THRESHOLD: r_threshold <= i_cfg_data;
                REG_CONFIRM_LENGTH: r_confirm   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register frees up when empty or taken this cycle
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_x <= i_pixel_x;
            r_in_y <= i_pixel_y;
        end
    end

    // distance is measured from the record as it stood before this word
    always_comb begin
        dx      = (r_rec_x >= r_in_x) ? (r_rec_x - r_in_x) : (r_in_x - r_rec_x);
        dy      = (r_rec_y >= r_in_y) ? (r_rec_y - r_in_y) : (r_in_y - r_rec_y);
        dx2     = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
        dy2     = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
        dist2   = CMP_BITS'(dx2) + CMP_BITS'(dy2);
        thr2    = CMP_BITS'(r_threshold) * CMP_BITS'(r_threshold);
        is_jump = dist2 > thr2;
        cnt_inc = (r_jump_count == CNT_MAX) ? r_jump_count : r_jump_count + 1'b1;
    end

    always_comb begin
        n_prev_x     = r_in_x;
        n_prev_y     = r_in_y;
        n_rec_x      = r_rec_x;
        n_rec_y      = r_rec_y;
        n_jump_count = r_jump_count;
        n_out_x      = r_in_x;
        n_out_y      = r_in_y;
        n_out_held   = 1'b0;
        if (is_jump) begin
            if (r_jump_count == '0) begin
                n_rec_x = r_prev_x;
                n_rec_y = r_prev_y;
            end
            if (CNT_BITS'(cnt_inc) >= CNT_BITS'(r_confirm)) begin
                n_jump_count = '0;
            end else begin
                n_jump_count = cnt_inc;
                n_out_x      = n_rec_x;
                n_out_y      = n_rec_y;
                n_out_held   = 1'b1;
            end
        end else begin
            n_jump_count = '0;
            n_rec_x      = r_in_x;
            n_rec_y      = r_in_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x     <= RST_X;
            r_prev_y     <= RST_Y;
            r_rec_x      <= RST_X;
            r_rec_y      <= RST_Y;
            r_jump_count <= '0;
        end else if (advance) begin
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            r_rec_x      <= n_rec_x;
            r_rec_y      <= n_rec_y;
            r_jump_count <= n_jump_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_held <= n_out_held;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_filtered_x = r_out_x;
    assign o_filtered_y = r_out_y;
    assign o_held       = r_out_held;

    `PJRF_ASSERT_NOW(a_held_has_count, i_clk, i_rst_n, r_out_valid && r_out_held, r_jump_count != '0, "held word shown with jump count at zero")
    `PJRF_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, !o_ready, r_in_valid && r_out_valid && !i_ready, "input stalled without a blocked result")
    `PJRF_ASSERT_NEXT(a_stall_holds_input, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_x) && $stable(r_in_y), "pending input word changed while stalled")
    `PJRF_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid, "result register empty after an advance")

endmodule
